@@ rtl/core/qxw_pkg.sv @@
// Shared types, widths and constants for the X-quadrotor motor mixer.
package qxw_pkg;

  // Field widths.
  localparam int IN_W    = 32;
  localparam int GAIN_W  = 32;
  localparam int SPEED_W = 24;
  localparam int FRAC_W  = 16;

  // Internal widths: exact product, rounded term, partial and full sums.
  localparam int PROD_W = IN_W + GAIN_W;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int PAIR_W = TERM_W + 2;
  localparam int SUM_W  = TERM_W + 3;

  // Square root radicand and number of recurrence steps (one result bit each).
  localparam int RAD_W      = 2 * SPEED_W;
  localparam int SQRT_STEPS = RAD_W / 2;

  // Half an LSB of the Q.16 result, added before truncation.
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  // Pipeline depth: three front stages, three mixing stages, the root chain.
  localparam int FRONT_STAGES = 3;
  localparam int MIX_STAGES   = 3;
  localparam int PIPE_DEPTH   = FRONT_STAGES + MIX_STAGES + SQRT_STEPS;

  // Motor order on the result ports.
  localparam int NUM_MOTORS  = 4;
  localparam int MOTOR_FL    = 0;
  localparam int MOTOR_RL    = 1;
  localparam int MOTOR_RR    = 2;
  localparam int MOTOR_FR    = 3;

  // Per-motor subtract masks for roll, pitch and yaw (bit i is motor i).
  localparam logic [NUM_MOTORS-1:0] NEG_ROLL  = 4'b1100;
  localparam logic [NUM_MOTORS-1:0] NEG_PITCH = 4'b1001;
  localparam logic [NUM_MOTORS-1:0] NEG_YAW   = 4'b1010;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRUST_GAIN = 3'd0,
    REG_ARM_GAIN    = 3'd1,
    REG_YAW_GAIN    = 3'd2,
    REG_MIN_SPEED   = 3'd3,
    REG_MAX_SPEED   = 3'd4
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]  GAIN_RESET      = 32'h0001_0000;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RESET = 24'h00_0000;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 24'hFF_FFFF;
  localparam logic [RAD_W-1:0]   MAX_SQ_RESET    = 48'hFFFF_FE00_0001;

  // Rounded term magnitudes and their signs, as handed to the mixer.
  typedef struct packed {
    logic [TERM_W-1:0] thrust;
    logic [TERM_W-1:0] roll;
    logic [TERM_W-1:0] pitch;
    logic [TERM_W-1:0] yaw;
    logic              roll_neg;
    logic              pitch_neg;
    logic              yaw_neg;
  } terms_t;

  // One lane of the square root recurrence.
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] root;
  } sqrt_lane_t;

  typedef sqrt_lane_t [NUM_MOTORS-1:0] sqrt_lanes_t;

endpackage

@@ rtl/core/qxw_front.sv @@
// Front end: magnitudes, gain products and rounding to Q.16.
module qxw_front import qxw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [IN_W-1:0]   thrust_i,
  input  logic signed [IN_W-1:0]   roll_i,
  input  logic signed [IN_W-1:0]   pitch_i,
  input  logic signed [IN_W-1:0]   yaw_i,
  input  logic        [GAIN_W-1:0] thrust_gain_i,
  input  logic        [GAIN_W-1:0] arm_gain_i,
  input  logic        [GAIN_W-1:0] yaw_gain_i,
  output logic                     valid_o,
  output terms_t                   terms_o
);

  // Stage one: magnitudes and signs.
  logic              s1_valid_q;
  logic [IN_W-1:0]   t_mag_q, r_mag_q, p_mag_q, y_mag_q;
  logic [IN_W-1:0]   t_mag_d, r_mag_d, p_mag_d, y_mag_d;
  logic              r_neg_q, p_neg_q, y_neg_q;

  // Stage two: exact products.
  logic              s2_valid_q;
  logic [PROD_W-1:0] t_prod_q, r_prod_q, p_prod_q, y_prod_q;
  logic              s2_r_neg_q, s2_p_neg_q, s2_y_neg_q;

  // Stage three: rounded terms.
  logic              s3_valid_q;
  terms_t            terms_q;
  logic [PROD_W-1:0] t_rnd, r_rnd, p_rnd, y_rnd;

  // A negative thrust counts as zero; torques are split into sign and magnitude.
  always_comb begin
    t_mag_d = thrust_i[IN_W-1] ? '0 : IN_W'(thrust_i);
    r_mag_d = roll_i[IN_W-1]  ? IN_W'(~roll_i + 1'b1)  : IN_W'(roll_i);
    p_mag_d = pitch_i[IN_W-1] ? IN_W'(~pitch_i + 1'b1) : IN_W'(pitch_i);
    y_mag_d = yaw_i[IN_W-1]   ? IN_W'(~yaw_i + 1'b1)   : IN_W'(yaw_i);
  end

  // Round half away from zero on the magnitude.
  always_comb begin
    t_rnd = t_prod_q + ROUND_HALF;
    r_rnd = r_prod_q + ROUND_HALF;
    p_rnd = p_prod_q + ROUND_HALF;
    y_rnd = y_prod_q + ROUND_HALF;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Payload registers load only with a valid item.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      t_mag_q <= t_mag_d;
      r_mag_q <= r_mag_d;
      p_mag_q <= p_mag_d;
      y_mag_q <= y_mag_d;
      r_neg_q <= roll_i[IN_W-1];
      p_neg_q <= pitch_i[IN_W-1];
      y_neg_q <= yaw_i[IN_W-1];
    end
    if (s1_valid_q) begin
      t_prod_q   <= PROD_W'(t_mag_q) * PROD_W'(thrust_gain_i);
      r_prod_q   <= PROD_W'(r_mag_q) * PROD_W'(arm_gain_i);
      p_prod_q   <= PROD_W'(p_mag_q) * PROD_W'(arm_gain_i);
      y_prod_q   <= PROD_W'(y_mag_q) * PROD_W'(yaw_gain_i);
      s2_r_neg_q <= r_neg_q;
      s2_p_neg_q <= p_neg_q;
      s2_y_neg_q <= y_neg_q;
    end
    if (s2_valid_q) begin
      terms_q.thrust    <= t_rnd[PROD_W-1:FRAC_W];
      terms_q.roll      <= r_rnd[PROD_W-1:FRAC_W];
      terms_q.pitch     <= p_rnd[PROD_W-1:FRAC_W];
      terms_q.yaw       <= y_rnd[PROD_W-1:FRAC_W];
      terms_q.roll_neg  <= s2_r_neg_q;
      terms_q.pitch_neg <= s2_p_neg_q;
      terms_q.yaw_neg   <= s2_y_neg_q;
    end
  end

  assign valid_o = s3_valid_q;
  assign terms_o = terms_q;

endmodule

@@ rtl/core/qxw_mix.sv @@
// Mixer: signed sums per motor, then the clamp to the squared speed limits.
module qxw_mix import qxw_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  terms_t                              terms_i,
  input  logic [RAD_W-1:0]                    min_sq_i,
  input  logic [RAD_W-1:0]                    max_sq_i,
  output logic                                valid_o,
  output logic [NUM_MOTORS-1:0][RAD_W-1:0]    sq_o
);

  logic                     s4_valid_q, s5_valid_q, s6_valid_q;
  logic signed [PAIR_W-1:0] a_q [NUM_MOTORS];
  logic signed [PAIR_W-1:0] b_q [NUM_MOTORS];
  logic signed [PAIR_W-1:0] a_d [NUM_MOTORS];
  logic signed [PAIR_W-1:0] b_d [NUM_MOTORS];
  logic signed [SUM_W-1:0]  sum_q [NUM_MOTORS];
  logic signed [SUM_W-1:0]  sum_d [NUM_MOTORS];
  logic [NUM_MOTORS-1:0][RAD_W-1:0] sq_q, sq_d;

  // Pair sums: thrust with roll, pitch with yaw.
  always_comb begin
    logic signed [PAIR_W-1:0] t_s, r_s, p_s, y_s;
    t_s = $signed({{(PAIR_W-TERM_W){1'b0}}, terms_i.thrust});
    r_s = $signed({{(PAIR_W-TERM_W){1'b0}}, terms_i.roll});
    p_s = $signed({{(PAIR_W-TERM_W){1'b0}}, terms_i.pitch});
    y_s = $signed({{(PAIR_W-TERM_W){1'b0}}, terms_i.yaw});
    for (int i = 0; i < NUM_MOTORS; i++) begin
      a_d[i] = t_s + ((NEG_ROLL[i] ^ terms_i.roll_neg) ? -r_s : r_s);
      b_d[i] = ((NEG_PITCH[i] ^ terms_i.pitch_neg) ? -p_s : p_s)
             + ((NEG_YAW[i] ^ terms_i.yaw_neg) ? -y_s : y_s);
    end
  end

  // Full squared speed.
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      sum_d[i] = $signed({a_q[i][PAIR_W-1], a_q[i]}) + $signed({b_q[i][PAIR_W-1], b_q[i]});
    end
  end

  // Clamp: below the low limit wins over the high limit.
  always_comb begin
    logic signed [SUM_W-1:0] lo_s, hi_s;
    lo_s = $signed({{(SUM_W-RAD_W){1'b0}}, min_sq_i});
    hi_s = $signed({{(SUM_W-RAD_W){1'b0}}, max_sq_i});
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (sum_q[i] < lo_s) begin
        sq_d[i] = min_sq_i;
      end else if (sum_q[i] > hi_s) begin
        sq_d[i] = max_sq_i;
      end else begin
        sq_d[i] = sum_q[i][RAD_W-1:0];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= valid_i;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (valid_i) begin
        a_q[i] <= a_d[i];
        b_q[i] <= b_d[i];
      end
      if (s4_valid_q) begin
        sum_q[i] <= sum_d[i];
      end
    end
    if (s5_valid_q) begin
      sq_q <= sq_d;
    end
  end

  assign valid_o = s6_valid_q;
  assign sq_o    = sq_q;

endmodule

@@ rtl/core/qxw_sqrt_stage.sv @@
// One step of the bit-pair square root recurrence, for all four motors.
module qxw_sqrt_stage import qxw_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  sqrt_lanes_t lanes_i,
  output logic        valid_o,
  output sqrt_lanes_t lanes_o
);

  // Weight of the bit pair tried in this step.
  localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (RAD_W - 2 - 2 * STEP);

  logic        valid_q;
  sqrt_lanes_t lanes_q, lanes_d;

  // Trial subtraction: keep it if the remainder covers it.
  always_comb begin
    logic [RAD_W-1:0] trial;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      trial = lanes_i[i].root + STEP_BIT;
      if (lanes_i[i].rem >= trial) begin
        lanes_d[i].rem  = lanes_i[i].rem - trial;
        lanes_d[i].root = (lanes_i[i].root >> 1) + STEP_BIT;
      end else begin
        lanes_d[i].rem  = lanes_i[i].rem;
        lanes_d[i].root = lanes_i[i].root >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

@@ rtl/core/qxw_sqrt.sv @@
// Pipelined floor square root: one result bit per stage, four lanes.
module qxw_sqrt import qxw_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [NUM_MOTORS-1:0][RAD_W-1:0]   sq_i,
  output logic                               valid_o,
  output logic [NUM_MOTORS-1:0][SPEED_W-1:0] speed_o
);

  logic [SQRT_STEPS:0] valid_chain;
  sqrt_lanes_t         lane_chain [SQRT_STEPS+1];

  // The radicand enters as the remainder with an empty root.
  always_comb begin
    valid_chain[0] = valid_i;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      lane_chain[0][i].rem  = sq_i[i];
      lane_chain[0][i].root = '0;
    end
  end

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    qxw_sqrt_stage #(
      .STEP(s)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_chain[s]),
      .lanes_i (lane_chain[s]),
      .valid_o (valid_chain[s+1]),
      .lanes_o (lane_chain[s+1])
    );
  end

  // After the last step the root fits the speed width.
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      speed_o[i] = lane_chain[SQRT_STEPS][i].root[SPEED_W-1:0];
    end
  end

  assign valid_o = valid_chain[SQRT_STEPS];

endmodule

@@ rtl/core/quad_x_wrench_to_motor_speed.sv @@
// Channel   Direction  Handshake             Payload
// command   in         start high, busy low  thrust_i, roll/pitch/yaw_torque_i
// result    out        done_o for one cycle  speed_front_left_o .. speed_front_right_o
// config    in         cfg_we_i              cfg_idx_i, cfg_data_i
//
// One item is taken in every cycle; busy never rises.
// Each result passes through the front stages for magnitudes, products and
// rounding, the mixing stages for mixing and clamping, and the square root
// chain, which settles one result bit per stage.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline advances in every cycle.
module quad_x_wrench_to_motor_speed import qxw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IN_W-1:0]   thrust_i,
  input  logic signed [IN_W-1:0]   roll_torque_i,
  input  logic signed [IN_W-1:0]   pitch_torque_i,
  input  logic signed [IN_W-1:0]   yaw_torque_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [GAIN_W-1:0]        cfg_data_i,
  output logic                     done_o,
  output logic [SPEED_W-1:0]       speed_front_left_o,
  output logic [SPEED_W-1:0]       speed_rear_left_o,
  output logic [SPEED_W-1:0]       speed_rear_right_o,
  output logic [SPEED_W-1:0]       speed_front_right_o
);

  logic [GAIN_W-1:0]  thrust_gain_q, arm_gain_q, yaw_gain_q;
  logic [SPEED_W-1:0] min_speed_q, max_speed_q;
  logic [RAD_W-1:0]   min_sq_q, max_sq_q, min_sq_d, max_sq_d;

  logic                               front_valid, mix_valid;
  terms_t                             terms;
  logic [NUM_MOTORS-1:0][RAD_W-1:0]   sq;
  logic [NUM_MOTORS-1:0][SPEED_W-1:0] speed;

  // The pipeline never refuses an item.
  assign busy = 1'b0;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thrust_gain_q <= GAIN_RESET;
      arm_gain_q    <= GAIN_RESET;
      yaw_gain_q    <= GAIN_RESET;
      min_speed_q   <= MIN_SPEED_RESET;
      max_speed_q   <= MAX_SPEED_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRUST_GAIN: thrust_gain_q <= cfg_data_i;
        REG_ARM_GAIN:    arm_gain_q    <= cfg_data_i;
        REG_YAW_GAIN:    yaw_gain_q    <= cfg_data_i;
        REG_MIN_SPEED:   min_speed_q   <= cfg_data_i[SPEED_W-1:0];
        REG_MAX_SPEED:   max_speed_q   <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared limits, registered from the speed registers.
  assign min_sq_d = RAD_W'(min_speed_q) * RAD_W'(min_speed_q);
  assign max_sq_d = RAD_W'(max_speed_q) * RAD_W'(max_speed_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sq_q <= '0;
      max_sq_q <= MAX_SQ_RESET;
    end else begin
      min_sq_q <= min_sq_d;
      max_sq_q <= max_sq_d;
    end
  end

  qxw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start & ~busy),
    .thrust_i      (thrust_i),
    .roll_i        (roll_torque_i),
    .pitch_i       (pitch_torque_i),
    .yaw_i         (yaw_torque_i),
    .thrust_gain_i (thrust_gain_q),
    .arm_gain_i    (arm_gain_q),
    .yaw_gain_i    (yaw_gain_q),
    .valid_o       (front_valid),
    .terms_o       (terms)
  );

  qxw_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (front_valid),
    .terms_i  (terms),
    .min_sq_i (min_sq_q),
    .max_sq_i (max_sq_q),
    .valid_o  (mix_valid),
    .sq_o     (sq)
  );

  qxw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .sq_i    (sq),
    .valid_o (done_o),
    .speed_o (speed)
  );

  assign speed_front_left_o  = speed[MOTOR_FL];
  assign speed_rear_left_o   = speed[MOTOR_RL];
  assign speed_rear_right_o  = speed[MOTOR_RR];
  assign speed_front_right_o = speed[MOTOR_FR];

endmodule

@@ rtl/core/qxw_checker.sv @@
// Port-level checks on the mixer's timing and result holding.
module qxw_checker import qxw_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [SPEED_W-1:0] speed_front_left_o,
  input logic [SPEED_W-1:0] speed_rear_left_o,
  input logic [SPEED_W-1:0] speed_rear_right_o,
  input logic [SPEED_W-1:0] speed_front_right_o
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] warm_q;
  logic             seen_q;

  // Cycles since reset, saturating at the pipeline depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
      seen_q <= 1'b0;
    end else begin
      if (warm_q != CNT_W'(PIPE_DEPTH)) begin
        warm_q <= warm_q + 1'b1;
      end
      if (done_o) begin
        seen_q <= 1'b1;
      end
    end
  end

  // Every accepted item gives its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_DEPTH done_o)
    else $error("accepted item gave no result after the pipeline depth");

  // No result without an item accepted the pipeline depth earlier.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && warm_q == CNT_W'(PIPE_DEPTH)) |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result strobe without a matching item");

  // Speeds change only together with a result strobe.
  a_speeds_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q && !done_o) |-> ($stable(speed_front_left_o) && $stable(speed_rear_left_o)
                             && $stable(speed_rear_right_o)
                             && $stable(speed_front_right_o)))
    else $error("speeds changed without a result strobe");

endmodule

bind quad_x_wrench_to_motor_speed qxw_checker u_qxw_checker (.*);

@@ dv/tb_quad_x_wrench_to_motor_speed.sv @@
`timescale 1ns / 100ps

module tb_quad_x_wrench_to_motor_speed;
  import qxw_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 9;
  localparam int WATCHDOG_LIMIT  = 1000;

  localparam logic signed [IN_W-1:0] FIELD_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] FIELD_MIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
  localparam logic [GAIN_W-1:0] HALF_GAIN  = GAIN_RESET >> 1;
  localparam logic [GAIN_W-1:0] SPEED_MASK = {{(GAIN_W-SPEED_W){1'b0}}, {SPEED_W{1'b1}}};

  typedef struct {
    logic signed [IN_W-1:0] thrust;
    logic signed [IN_W-1:0] roll_torque;
    logic signed [IN_W-1:0] pitch_torque;
    logic signed [IN_W-1:0] yaw_torque;
  } wrench_t;

  typedef struct {
    logic [SPEED_W-1:0] front_left;
    logic [SPEED_W-1:0] rear_left;
    logic [SPEED_W-1:0] rear_right;
    logic [SPEED_W-1:0] front_right;
  } speeds_t;

  // Scoreboard: keeps its own copy of the mixer settings, works out the four
  // motor speeds of every accepted wrench and compares them with the results.
  class speed_scoreboard;
    logic [GAIN_W-1:0]  thrust_gain;
    logic [GAIN_W-1:0]  arm_gain;
    logic [GAIN_W-1:0]  yaw_gain;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;
    speeds_t            pending_speeds[$];
    int unsigned        mismatches;

    function new();
      thrust_gain = GAIN_RESET;
      arm_gain    = GAIN_RESET;
      yaw_gain    = GAIN_RESET;
      min_speed   = MIN_SPEED_RESET;
      max_speed   = MAX_SPEED_RESET;
      mismatches  = 0;
    endfunction

    // Unknown indexes are ignored; speed registers keep their low bits only.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        REG_THRUST_GAIN: thrust_gain = data;
        REG_ARM_GAIN:    arm_gain    = data;
        REG_YAW_GAIN:    yaw_gain    = data;
        REG_MIN_SPEED:   min_speed   = data[SPEED_W-1:0];
        REG_MAX_SPEED:   max_speed   = data[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact product rounded to Q.16 on its magnitude, half away from zero.
    function longint scaled_term(longint x, logic [GAIN_W-1:0] g, bit neg);
      longint unsigned mag;
      bit              flip;
      flip = neg;
      if (x < 0) begin
        mag  = -x;
        flip = !flip;
      end else begin
        mag = x;
      end
      mag = (mag * 64'(g) + ROUND_HALF) >> FRAC_W;
      return flip ? -longint'(mag) : longint'(mag);
    endfunction

    // Floor square root, one result bit at a time from the top.
    function logic [SPEED_W-1:0] floor_root(longint v);
      logic [SPEED_W-1:0] root;
      logic [SPEED_W-1:0] trial;
      longint             square;
      int                 b;
      root = '0;
      for (b = SPEED_W - 1; b >= 0; b--) begin
        trial    = root;
        trial[b] = 1'b1;
        square   = longint'(trial);
        square   = square * square;
        if (square <= v) root = trial;
      end
      return root;
    endfunction

    function speeds_t mix_speeds(wrench_t w);
      logic [SPEED_W-1:0] root_of [NUM_MOTORS];
      longint             t, base, sq, lo, hi;
      speeds_t            s;
      int                 m;
      lo = longint'(min_speed);
      lo = lo * lo;
      hi = longint'(max_speed);
      hi = hi * hi;
      t  = longint'(w.thrust);
      if (t < 0) t = 0;
      base = scaled_term(t, thrust_gain, 1'b0);
      for (m = 0; m < NUM_MOTORS; m++) begin
        sq = base + scaled_term(longint'(w.roll_torque), arm_gain, NEG_ROLL[m])
                  + scaled_term(longint'(w.pitch_torque), arm_gain, NEG_PITCH[m])
                  + scaled_term(longint'(w.yaw_torque), yaw_gain, NEG_YAW[m]);
        // A low value wins over a high limit when min is above max.
        if (sq < lo) sq = lo;
        else if (sq > hi) sq = hi;
        root_of[m] = floor_root(sq);
      end
      s.front_left  = root_of[MOTOR_FL];
      s.rear_left   = root_of[MOTOR_RL];
      s.rear_right  = root_of[MOTOR_RR];
      s.front_right = root_of[MOTOR_FR];
      return s;
    endfunction

    function void note_wrench(wrench_t w);
      pending_speeds.push_back(mix_speeds(w));
    endfunction

    function void compare_field(string name, logic [SPEED_W-1:0] want,
                                logic [SPEED_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_speeds(speeds_t got);
      speeds_t want;
      if (pending_speeds.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item outstanding, got %0d %0d %0d %0d", $time,
                 got.front_left, got.rear_left, got.rear_right, got.front_right);
      end else begin
        want = pending_speeds.pop_front();
        compare_field("speed_front_left", want.front_left, got.front_left);
        compare_field("speed_rear_left", want.rear_left, got.rear_left);
        compare_field("speed_rear_right", want.rear_right, got.rear_right);
        compare_field("speed_front_right", want.front_right, got.front_right);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic signed [IN_W-1:0] thrust_i;
  logic signed [IN_W-1:0] roll_torque_i;
  logic signed [IN_W-1:0] pitch_torque_i;
  logic signed [IN_W-1:0] yaw_torque_i;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [GAIN_W-1:0]      cfg_data_i;
  logic                   done_o;
  logic [SPEED_W-1:0]     speed_front_left_o;
  logic [SPEED_W-1:0]     speed_rear_left_o;
  logic [SPEED_W-1:0]     speed_rear_right_o;
  logic [SPEED_W-1:0]     speed_front_right_o;

  speed_scoreboard sb = new();
  int              idle_cycles = 0;
  wrench_t         seen_wrench;
  speeds_t         seen_speeds;

  quad_x_wrench_to_motor_speed dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .thrust_i            (thrust_i),
    .roll_torque_i       (roll_torque_i),
    .pitch_torque_i      (pitch_torque_i),
    .yaw_torque_i        (yaw_torque_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .done_o              (done_o),
    .speed_front_left_o  (speed_front_left_o),
    .speed_rear_left_o   (speed_rear_left_o),
    .speed_rear_right_o  (speed_rear_right_o),
    .speed_front_right_o (speed_front_right_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: register writes, accepted items and results, all sampled at the
  // rising edge before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (start && !busy) begin
        seen_wrench.thrust       = thrust_i;
        seen_wrench.roll_torque  = roll_torque_i;
        seen_wrench.pitch_torque = pitch_torque_i;
        seen_wrench.yaw_torque   = yaw_torque_i;
        sb.note_wrench(seen_wrench);
      end
      if (done_o) begin
        seen_speeds.front_left  = speed_front_left_o;
        seen_speeds.rear_left   = speed_rear_left_o;
        seen_speeds.rear_right  = speed_rear_right_o;
        seen_speeds.front_right = speed_front_right_o;
        sb.check_speeds(seen_speeds);
      end
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Watchdog on cycles in which nothing moves.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic wrench_t make_wrench(logic signed [IN_W-1:0] t, r, p, y);
    wrench_t w;
    w.thrust       = t;
    w.roll_torque  = r;
    w.pitch_torque = p;
    w.yaw_torque   = y;
    return w;
  endfunction

  // Field values: full range, small magnitudes of either sign and the extremes.
  function automatic logic signed [IN_W-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom >> $urandom_range(0, IN_W - 1);
      1: return -($urandom >> $urandom_range(1, IN_W - 1));
      2: begin
        case ($urandom_range(0, 3))
          0: return FIELD_MAX;
          1: return FIELD_MIN;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly positive thrust, as in flight; the rest anything at all.
  function automatic wrench_t rand_wrench();
    logic signed [IN_W-1:0] t;
    t = rand_field();
    if ($urandom_range(0, 3) != 0) t = t & FIELD_MAX;
    return make_wrench(t, rand_field(), rand_field(), rand_field());
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_MAX;
      2: return GAIN_RESET;
      3: return $urandom;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] rand_speed();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return MAX_SPEED_RESET;
      2: return SPEED_W'($urandom);
      default: return SPEED_W'($urandom_range(0, 1 << 17));
    endcase
  endfunction

  // Speed register data with random junk above the register width.
  function automatic logic [GAIN_W-1:0] speed_data(logic [SPEED_W-1:0] s);
    return ($urandom & ~SPEED_MASK) | GAIN_W'(s);
  endfunction

  task automatic send_wrench(wrench_t w);
    start          <= 1'b1;
    thrust_i       <= w.thrust;
    roll_torque_i  <= w.roll_torque;
    pitch_torque_i <= w.pitch_torque;
    yaw_torque_i   <= w.yaw_torque;
    do @(posedge clk_i); while (busy);
  endtask

  // Idle burst with junk on the fields, which the block must ignore.
  task automatic idle_gap(int cycles);
    start          <= 1'b0;
    thrust_i       <= $urandom;
    roll_torque_i  <= $urandom;
    pitch_torque_i <= $urandom;
    yaw_torque_i   <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold the next item back until every outstanding result has come.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (sb.pending_speeds.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Full set of registers, then writes to the unused indexes.
  task automatic load_settings(logic [GAIN_W-1:0] tg, ag, yg, mn, mx);
    int i;
    cfg_put(REG_THRUST_GAIN, tg);
    cfg_put(REG_ARM_GAIN, ag);
    cfg_put(REG_YAW_GAIN, yg);
    cfg_put(REG_MIN_SPEED, mn);
    cfg_put(REG_MAX_SPEED, mx);
    for (i = REG_MAX_SPEED + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_put(CFG_IDX_W'(i), $urandom);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int                 p;
    int                 n;
    int                 idle_pct;
    logic [SPEED_W-1:0] sa;
    logic [SPEED_W-1:0] sb_speed;

    rst_ni         <= 1'b0;
    start          <= 1'b0;
    thrust_i       <= '0;
    roll_torque_i  <= '0;
    pitch_torque_i <= '0;
    yaw_torque_i   <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset settings: extremes of every field,
    // negative thrust and negative squared speeds.
    send_wrench(make_wrench(0, 0, 0, 0));
    send_wrench(make_wrench(FIELD_MAX, 0, 0, 0));
    send_wrench(make_wrench(FIELD_MIN, 0, 0, 0));
    send_wrench(make_wrench(-1, 0, 0, 0));
    send_wrench(make_wrench(0, FIELD_MAX, 0, 0));
    send_wrench(make_wrench(0, FIELD_MIN, 0, 0));
    send_wrench(make_wrench(0, 0, FIELD_MAX, 0));
    send_wrench(make_wrench(0, 0, FIELD_MIN, 0));
    send_wrench(make_wrench(0, 0, 0, FIELD_MAX));
    send_wrench(make_wrench(0, 0, 0, FIELD_MIN));
    send_wrench(make_wrench(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_wrench(make_wrench(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_wrench(make_wrench(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_wrench(make_wrench(-1, -1, -1, -1));
    wait_drained();

    // Half gains put products exactly on the rounding midpoint.
    load_settings(HALF_GAIN, HALF_GAIN, HALF_GAIN, speed_data(SPEED_W'(3)),
                  speed_data(MAX_SPEED_RESET));
    send_wrench(make_wrench(1, 0, 0, 0));
    send_wrench(make_wrench(0, 1, 0, 0));
    send_wrench(make_wrench(0, -1, 0, 0));
    send_wrench(make_wrench(0, 0, 3, -1));
    send_wrench(make_wrench(3, -3, 1, 1));
    send_wrench(make_wrench(FIELD_MAX, 0, FIELD_MIN, 1));
    wait_drained();

    // Random phases, each under its own settings.
    for (p = 0; p < NUM_PHASES; p++) begin
      sa       = rand_speed();
      sb_speed = rand_speed();
      case (p)
        0: load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, ~SPEED_MASK, '1);
        1: load_settings('0, '0, '0, speed_data(sa), speed_data(sb_speed));
        2: begin
          // Lower limit above the upper one.
          if (sa < sb_speed) {sa, sb_speed} = {sb_speed, sa};
          load_settings(rand_gain(), rand_gain(), rand_gain(),
                        speed_data(sa), speed_data(sb_speed));
        end
        default: begin
          if (sa > sb_speed && $urandom_range(0, 3) != 0) {sa, sb_speed} = {sb_speed, sa};
          load_settings(rand_gain(), rand_gain(), rand_gain(),
                        speed_data(sa), speed_data(sb_speed));
        end
      endcase
      idle_pct = (p == NUM_PHASES - 1) ? 0 : $urandom_range(0, 40);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_wrench(rand_wrench());
        if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 4));
        else if (idle_pct != 0 && $urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_speeds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ quad_x_wrench_to_motor_speed.f @@
rtl/core/qxw_pkg.sv
rtl/core/qxw_front.sv
rtl/core/qxw_mix.sv
rtl/core/qxw_sqrt_stage.sv
rtl/core/qxw_sqrt.sv
rtl/core/quad_x_wrench_to_motor_speed.sv
rtl/core/qxw_checker.sv
dv/tb_quad_x_wrench_to_motor_speed.sv
